// ===== design/xpld_pkg.sv =====
package xpld_pkg;

   localparam int MAX_STEAL_DEFAULT = 64;
   localparam int MIN_W             = 7;
   localparam logic [MIN_W-1:0] MIN_BYTES_RESET = 7'd14;

   // code bytes of the supported subset
   localparam logic [7:0] OP_REP       = 8'hF3;
   localparam logic [7:0] OP_ESC       = 8'h0F;
   localparam logic [7:0] ENDBR_B2     = 8'h1E;
   localparam logic [7:0] ENDBR_B3     = 8'hFA;
   localparam logic [7:0] OP_OPSIZE    = 8'h66;
   localparam logic [7:0] REX_MASK     = 8'hF0;
   localparam logic [7:0] REX_BASE     = 8'h40;
   localparam logic [7:0] OP_PUSH_LO   = 8'h50;
   localparam logic [7:0] OP_POP_HI    = 8'h5F;
   localparam logic [7:0] OP_NOP       = 8'h90;
   localparam logic [7:0] OP_RET       = 8'hC3;
   localparam logic [7:0] OP_INT3      = 8'hCC;
   localparam logic [7:0] OP_GRP1_EB   = 8'h80;
   localparam logic [7:0] OP_GRP1_IB   = 8'h83;
   localparam logic [7:0] OP_MOV_EB_IB = 8'hC6;
   localparam logic [7:0] OP_GRP1_IZ   = 8'h81;
   localparam logic [7:0] OP_MOV_EV_IZ = 8'hC7;
   localparam logic [7:0] OP_MOV_RI_LO = 8'hB8;
   localparam logic [7:0] OP_MOV_RI_HI = 8'hBF;

   localparam logic [1:0] MOD_NONE  = 2'd0;
   localparam logic [1:0] MOD_D8    = 2'd1;
   localparam logic [1:0] MOD_D32   = 2'd2;
   localparam logic [1:0] MOD_REG   = 2'd3;
   localparam logic [2:0] RM_SIB    = 3'd4;
   localparam logic [2:0] RM_DISP   = 3'd5;

   typedef enum logic [9:0] {
      PH_IDLE   = 10'b00_0000_0001,
      PH_START  = 10'b00_0000_0010,
      PH_AFT66  = 10'b00_0000_0100,
      PH_AFTREX = 10'b00_0000_1000,
      PH_ENDBR  = 10'b00_0001_0000,
      PH_OP2    = 10'b00_0010_0000,
      PH_MODRM  = 10'b00_0100_0000,
      PH_SIB    = 10'b00_1000_0000,
      PH_SKIP   = 10'b01_0000_0000,
      PH_DONE   = 10'b10_0000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       first;
   } req_type;

   typedef struct packed {
      logic [6:0] steal_length;
      logic       accepted;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      req_type data;
   } step_type;

   function automatic logic is_modrm_op(input logic [7:0] op);
      logic r;
      unique case (op)
         8'h01, 8'h03, 8'h09, 8'h0B, 8'h21, 8'h23, 8'h29, 8'h2B, 8'h31, 8'h33,
         8'h39, 8'h3B, 8'h84, 8'h85, 8'h87, 8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8D,
         8'h63: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic is_op2(input logic [7:0] op);
      logic r;
      unique case (op)
         8'h1F, 8'hB6, 8'hB7, 8'hBE, 8'hBF, 8'h10, 8'h11, 8'h28, 8'h29, 8'h57,
         8'hEF: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] disp_for_mod(input logic [1:0] md);
      logic [2:0] r;
      unique case (md)
         MOD_D8:  r = 3'd1;
         MOD_D32: r = 3'd4;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== design/xpld_decode.sv =====
module xpld_decode #(
   parameter int MAX_STEAL = xpld_pkg::MAX_STEAL_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [xpld_pkg::MIN_W-1:0] min_bytes,
   input  xpld_pkg::step_type         step,
   output logic                       res_valid,
   output xpld_pkg::rsp_type          res
);

   localparam int TW = $clog2(MAX_STEAL + 2);
   localparam int CW = (TW > xpld_pkg::MIN_W) ? TW : xpld_pkg::MIN_W;
   localparam logic [CW-1:0] LIMIT = CW'(MAX_STEAL);

   xpld_pkg::phase_type phase_ff, phase_in;
   logic [TW-1:0] total_ff, total_in;
   logic [3:0]    pend_ff, pend_in;
   logic [2:0]    imm_ff, imm_in;
   logic          opsize_ff, opsize_in;
   logic          rexw_ff, rexw_in;
   logic [1:0]    mod_ff, mod_in;
   logic [1:0]    endbr_ff, endbr_in;

   logic          active, is_end, bad, opcode_slot, pend_set;
   logic [3:0]    pend_n;
   logic [7:0]    b, want;
   logic [2:0]    d_sib;
   logic [CW-1:0] total_x, need;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= xpld_pkg::PH_IDLE;
         total_ff  <= '0;
         pend_ff   <= '0;
         imm_ff    <= '0;
         opsize_ff <= 1'b0;
         rexw_ff   <= 1'b0;
         mod_ff    <= '0;
         endbr_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         total_ff  <= total_in;
         pend_ff   <= pend_in;
         imm_ff    <= imm_in;
         opsize_ff <= opsize_in;
         rexw_ff   <= rexw_in;
         mod_ff    <= mod_in;
         endbr_ff  <= endbr_in;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      total_in    = total_ff;
      pend_in     = pend_ff;
      imm_in      = imm_ff;
      opsize_in   = opsize_ff;
      rexw_in     = rexw_ff;
      mod_in      = mod_ff;
      endbr_in    = endbr_ff;
      active      = 1'b0;
      is_end      = 1'b0;
      bad         = 1'b0;
      opcode_slot = 1'b0;
      pend_set    = 1'b0;
      pend_n      = '0;
      want        = xpld_pkg::ENDBR_B3;
      d_sib       = '0;
      res_valid   = 1'b0;
      res         = '0;
      b           = step.data.code_byte;
      total_x     = '0;
      need        = '0;

      if (step.valid) begin
         if (step.data.first) begin
            phase_in = xpld_pkg::PH_START;
            total_in = '0;
            pend_in  = '0;
            imm_in   = '0;
            mod_in   = '0;
            endbr_in = '0;
         end
         active = (phase_in != xpld_pkg::PH_IDLE) && (phase_in != xpld_pkg::PH_DONE);
      end

      if (active) begin
         total_in = total_in + 1'b1;
         unique case (phase_in)
            xpld_pkg::PH_START: begin
               opsize_in = 1'b0;
               rexw_in   = 1'b0;
               if (b == xpld_pkg::OP_REP) begin
                  endbr_in = 2'd1;
                  phase_in = xpld_pkg::PH_ENDBR;
               end else if (b == xpld_pkg::OP_OPSIZE) begin
                  opsize_in = 1'b1;
                  phase_in  = xpld_pkg::PH_AFT66;
               end else if ((b & xpld_pkg::REX_MASK) == xpld_pkg::REX_BASE) begin
                  rexw_in  = b[3];
                  phase_in = xpld_pkg::PH_AFTREX;
               end else begin
                  opcode_slot = 1'b1;
               end
            end
            xpld_pkg::PH_AFT66: begin
               if ((b & xpld_pkg::REX_MASK) == xpld_pkg::REX_BASE) begin
                  rexw_in  = b[3];
                  phase_in = xpld_pkg::PH_AFTREX;
               end else begin
                  opcode_slot = 1'b1;
               end
            end
            xpld_pkg::PH_AFTREX: opcode_slot = 1'b1;
            xpld_pkg::PH_ENDBR: begin
               want = (endbr_ff == 2'd1) ? xpld_pkg::OP_ESC :
                      (endbr_ff == 2'd2) ? xpld_pkg::ENDBR_B2 : xpld_pkg::ENDBR_B3;
               if (b != want) begin
                  bad = 1'b1;
               end else begin
                  endbr_in = endbr_ff + 2'd1;
                  is_end   = (endbr_in == 2'd0);
               end
            end
            xpld_pkg::PH_OP2: begin
               if (xpld_pkg::is_op2(b)) begin
                  imm_in   = '0;
                  phase_in = xpld_pkg::PH_MODRM;
               end else begin
                  bad = 1'b1;
               end
            end
            xpld_pkg::PH_MODRM: begin
               mod_in = b[7:6];
               if (b[7:6] == xpld_pkg::MOD_REG) begin
                  pend_set = 1'b1;
                  pend_n   = {1'b0, imm_ff};
               end else if (b[2:0] == xpld_pkg::RM_SIB) begin
                  phase_in = xpld_pkg::PH_SIB;
               end else if (b[7:6] == xpld_pkg::MOD_NONE && b[2:0] == xpld_pkg::RM_DISP) begin
                  bad = 1'b1;  // RIP-relative
               end else begin
                  pend_set = 1'b1;
                  pend_n   = {1'b0, xpld_pkg::disp_for_mod(b[7:6])} + {1'b0, imm_ff};
               end
            end
            xpld_pkg::PH_SIB: begin
               d_sib = (mod_ff == xpld_pkg::MOD_NONE && b[2:0] == xpld_pkg::RM_DISP) ?
                       3'd4 : xpld_pkg::disp_for_mod(mod_ff);
               pend_set = 1'b1;
               pend_n   = {1'b0, d_sib} + {1'b0, imm_ff};
            end
            xpld_pkg::PH_SKIP: begin
               pend_in = pend_ff - 4'd1;
               is_end  = (pend_in == 4'd0);
            end
            default: begin
               phase_in = xpld_pkg::PH_DONE;
            end
         endcase

         // opcode byte of an instruction
         if (opcode_slot) begin
            priority if ((b >= xpld_pkg::OP_PUSH_LO && b <= xpld_pkg::OP_POP_HI) ||
                         b == xpld_pkg::OP_NOP || b == xpld_pkg::OP_RET ||
                         b == xpld_pkg::OP_INT3) begin
               is_end = 1'b1;
            end else if (xpld_pkg::is_modrm_op(b)) begin
               imm_in   = '0;
               phase_in = xpld_pkg::PH_MODRM;
            end else if (b == xpld_pkg::OP_GRP1_EB || b == xpld_pkg::OP_GRP1_IB ||
                         b == xpld_pkg::OP_MOV_EB_IB) begin
               imm_in   = 3'd1;
               phase_in = xpld_pkg::PH_MODRM;
            end else if (b == xpld_pkg::OP_GRP1_IZ || b == xpld_pkg::OP_MOV_EV_IZ) begin
               imm_in   = (opsize_in && !rexw_in) ? 3'd2 : 3'd4;
               phase_in = xpld_pkg::PH_MODRM;
            end else if (b >= xpld_pkg::OP_MOV_RI_LO && b <= xpld_pkg::OP_MOV_RI_HI) begin
               pend_set = 1'b1;
               pend_n   = rexw_in ? 4'd8 : (opsize_in ? 4'd2 : 4'd4);
            end else if (b == xpld_pkg::OP_ESC) begin
               phase_in = xpld_pkg::PH_OP2;
            end else begin
               bad = 1'b1;
            end
         end

         if (pend_set) begin
            pend_in = pend_n;
            if (pend_n == 4'd0) begin
               is_end = 1'b1;
            end else begin
               phase_in = xpld_pkg::PH_SKIP;
            end
         end

         total_x = CW'(total_in);
         need    = (min_bytes == '0) ? CW'(1) : CW'(min_bytes);
         if (phase_in != xpld_pkg::PH_DONE) begin
            if (bad || total_x > LIMIT) begin
               phase_in  = xpld_pkg::PH_DONE;
               res_valid = 1'b1;
            end else if (is_end) begin
               if (total_x >= need) begin
                  phase_in         = xpld_pkg::PH_DONE;
                  res_valid        = 1'b1;
                  res.steal_length = total_x[6:0];
                  res.accepted     = 1'b1;
               end else begin
                  phase_in = xpld_pkg::PH_START;
               end
            end
         end
      end
   end

endmodule

// ===== design/x86_prologue_length_decoder.sv =====
// x86-64 prologue length decoder.
// req channel: one code byte per transfer, with a flag marking the first byte
// of a new prologue; a marked byte restarts decoding.
// rsp channel: at most one result per byte. A result is sent at the first
// instruction boundary where the covered byte count reaches min_bytes
// (accepted, with the count), or on an unsupported instruction, a
// RIP-relative operand, or a count above MAX_STEAL (refused, length 0).
// After a result, bytes are dropped until the next first-marked byte.
// csr channel: writes min_bytes (0 acts as 1); always ready, write only when
// the block is idle.
// The path runs from a req transfer into the input register, then through the
// decode logic into the result register, which loads while no result is stalled.
// Throughput: one byte per cycle while no result is held stalled; the decode
// step is a single pass of narrow logic over the byte and state.
// When the receiver stalls with a result held, decoding stops and the input
// register holds one byte; req_ready drops once that register is full.
// Reset clears the valid flag of both registers, returns to waiting for a
// first-marked byte and sets min_bytes to 14.
module x86_prologue_length_decoder #(
   parameter int MAX_STEAL = xpld_pkg::MAX_STEAL_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  xpld_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output xpld_pkg::rsp_type          rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [xpld_pkg::MIN_W-1:0] csr_data
);

   logic                       in_valid_ff, in_valid_in;
   xpld_pkg::req_type          in_data_ff, in_data_in;
   logic                       out_valid_ff, out_valid_in;
   xpld_pkg::rsp_type          out_data_ff, out_data_in;
   logic [xpld_pkg::MIN_W-1:0] min_bytes_ff, min_bytes_in;

   logic               adv, consume;
   xpld_pkg::step_type step;
   logic               dec_valid;
   xpld_pkg::rsp_type  dec_res;

   assign adv       = !out_valid_ff || rsp_ready;
   assign consume   = in_valid_ff && adv;
   assign req_ready = !in_valid_ff || adv;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign step.valid = consume;
   assign step.data  = in_data_ff;

   xpld_decode #(
      .MAX_STEAL (MAX_STEAL)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .min_bytes (min_bytes_ff),
      .step      (step),
      .res_valid (dec_valid),
      .res       (dec_res)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      min_bytes_in = min_bytes_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
      if (adv) begin
         out_valid_in = dec_valid;
         out_data_in  = dec_res;
      end
      if (csr_valid && csr_ready) begin
         min_bytes_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         min_bytes_ff <= xpld_pkg::MIN_BYTES_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         min_bytes_ff <= min_bytes_in;
      end
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   a_refuse_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.accepted) |-> (rsp_data.steal_length == '0))
      else $error("refusal with nonzero length");

   a_result_needs_byte: assert property (@(posedge clock) disable iff (reset)
      dec_valid |-> consume)
      else $error("result produced without a decoded byte");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !adv) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("input register lost a byte during stall");

endmodule
